// ===== rtl/core/dllm_pkg.sv =====
// Shared types, constants and helpers for the doubly linked list manager.
`timescale 1ns / 1ps
`default_nettype none

package dllm_pkg;

  localparam int POOL_NODES   = 64;
  localparam int NODE_BITS    = $clog2(POOL_NODES);
  localparam int LINK_BITS    = NODE_BITS + 1;
  localparam int PAYLOAD_BITS = 32;
  localparam int OP_BITS      = 3;

  typedef logic [NODE_BITS-1:0]    node_t;
  typedef logic [LINK_BITS-1:0]    link_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;

  // A link equal to the pool size means no node
  localparam link_t LINK_NONE = link_t'(POOL_NODES);

  typedef enum logic [OP_BITS-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_BACK   = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_REM_FRONT  = 3'd4,
    OP_REM_BACK   = 3'd5,
    OP_REM_NODE   = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  // One write port per node store
  typedef struct packed {
    logic  prev_we;
    node_t prev_addr;
    link_t prev_link;
    logic  next_we;
    node_t next_addr;
    link_t next_link;
    logic  data_we;
    node_t data_addr;
    word_t data_word;
  } mem_wr_t;

  // Registered read data of all three stores at one slot
  typedef struct packed {
    link_t prev_link;
    link_t next_link;
    word_t data_word;
  } mem_rd_t;

  function automatic logic is_slot(link_t v);
    return v < LINK_NONE;
  endfunction

  function automatic link_t to_link(node_t n);
    return {1'b0, n};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dllm_if.sv =====
// Valid/ready channel interfaces for list operations and their results.
`timescale 1ns / 1ps
`default_nettype none

interface dllm_in_if;
  logic                        valid;
  logic                        ready;
  logic [dllm_pkg::OP_BITS-1:0] operation;
  dllm_pkg::node_t             node_index;
  dllm_pkg::node_t             anchor_index;
  dllm_pkg::word_t             payload;

  modport source (output valid, operation, node_index, anchor_index, payload, input ready);
  modport sink   (input valid, operation, node_index, anchor_index, payload, output ready);
endinterface

interface dllm_out_if;
  logic            valid;
  logic            ready;
  logic            removed_valid;
  dllm_pkg::node_t removed_node;
  dllm_pkg::word_t removed_data;
  logic            list_empty;

  modport source (output valid, removed_valid, removed_node, removed_data, list_empty,
                  input ready);
  modport sink   (input valid, removed_valid, removed_node, removed_data, list_empty,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/doubly_linked_list_manager.sv =====
// Top level: doubly linked list manager over a fixed pool of node slots.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        operation, node_index, anchor_index, payload
//  out_ch    out  valid/ready        removed_valid, removed_node, removed_data, list_empty
//
// Each item passes through accept (slot read), link update and neighbor fix-up;
// the single write port of each node store is why link update and fix-up are separate.
// The result register frees the input side: a new item is accepted while a
// result waits, but after the fix-up cycle the sequencer waits until the
// result register is free, and the input stays not ready meanwhile.
// Reset (rst_n low, synchronous) empties the list; slot contents are kept and
// need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_manager (
  input wire logic     clk,
  input wire logic     rst_n,
  dllm_in_if.sink      in_ch,
  dllm_out_if.source   out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LINK = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  dllm_pkg::link_t   front_r, front_nxt;
  dllm_pkg::link_t   back_r, back_nxt;
  logic              out_valid_r, out_valid_nxt;

  dllm_pkg::op_t     op_r;
  dllm_pkg::node_t   node_r;
  dllm_pkg::node_t   anchor_r;
  dllm_pkg::word_t   data_r;
  logic              go_r;
  logic              res_valid_r, res_valid_nxt;
  dllm_pkg::node_t   res_node_r, res_node_nxt;

  logic              out_removed_valid_r;
  dllm_pkg::node_t   out_removed_node_r;
  dllm_pkg::word_t   out_removed_data_r;
  logic              out_list_empty_r;

  dllm_pkg::op_t     in_op;
  logic              in_acc;
  logic              in_go;
  logic              out_free;
  logic              out_load;
  dllm_pkg::node_t   rd_addr;
  dllm_pkg::mem_wr_t wr;
  dllm_pkg::mem_rd_t rd;
  dllm_pkg::link_t   nf, nb;

  assign in_op       = dllm_pkg::op_t'(in_ch.operation);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Pick the slot whose links the operation follows
  always_comb begin
    case (in_op)
      dllm_pkg::OP_REM_FRONT:
        rd_addr = front_r[dllm_pkg::NODE_BITS-1:0];
      dllm_pkg::OP_REM_BACK:
        rd_addr = back_r[dllm_pkg::NODE_BITS-1:0];
      dllm_pkg::OP_INS_AFTER, dllm_pkg::OP_INS_BEFORE:
        rd_addr = in_ch.anchor_index;
      default:
        rd_addr = in_ch.node_index;
    endcase
  end

  // End removals act only on a non-empty list
  always_comb begin
    case (in_op)
      dllm_pkg::OP_REM_FRONT: in_go = dllm_pkg::is_slot(front_r);
      dllm_pkg::OP_REM_BACK:  in_go = dllm_pkg::is_slot(back_r);
      default:                in_go = 1'b1;
    endcase
  end

  dllm_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  // Sequencer: link update, then neighbor fix-up and result hand-off
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    res_valid_nxt = res_valid_r;
    res_node_nxt  = res_node_r;
    out_load      = 1'b0;
    wr            = '0;
    nf            = front_r;
    nb            = back_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LINK;
        end
      end

      ST_LINK: begin
        state_nxt     = ST_FIX;
        res_valid_nxt = 1'b0;
        res_node_nxt  = '0;
        case (op_r)
          dllm_pkg::OP_INS_FRONT: begin
            wr.prev_we   = dllm_pkg::is_slot(front_r);
            wr.prev_addr = front_r[dllm_pkg::NODE_BITS-1:0];
            wr.prev_link = dllm_pkg::to_link(node_r);
            wr.next_we   = 1'b1;
            wr.next_addr = node_r;
            wr.next_link = front_r;
            wr.data_we   = 1'b1;
            wr.data_addr = node_r;
            wr.data_word = data_r;
            front_nxt    = dllm_pkg::to_link(node_r);
            if (!dllm_pkg::is_slot(back_r)) begin
              back_nxt = dllm_pkg::to_link(node_r);
            end
          end
          dllm_pkg::OP_INS_BACK: begin
            wr.next_we   = dllm_pkg::is_slot(back_r);
            wr.next_addr = back_r[dllm_pkg::NODE_BITS-1:0];
            wr.next_link = dllm_pkg::to_link(node_r);
            wr.prev_we   = 1'b1;
            wr.prev_addr = node_r;
            wr.prev_link = back_r;
            wr.data_we   = 1'b1;
            wr.data_addr = node_r;
            wr.data_word = data_r;
            back_nxt     = dllm_pkg::to_link(node_r);
            if (!dllm_pkg::is_slot(front_r)) begin
              front_nxt = dllm_pkg::to_link(node_r);
            end
          end
          dllm_pkg::OP_INS_AFTER: begin
            wr.prev_we   = 1'b1;
            wr.prev_addr = node_r;
            wr.prev_link = dllm_pkg::to_link(anchor_r);
            wr.next_we   = 1'b1;
            wr.next_addr = node_r;
            wr.next_link = rd.next_link;
            wr.data_we   = 1'b1;
            wr.data_addr = node_r;
            wr.data_word = data_r;
            if (back_r == dllm_pkg::to_link(anchor_r)) begin
              back_nxt = dllm_pkg::to_link(node_r);
            end
          end
          dllm_pkg::OP_INS_BEFORE: begin
            wr.next_we   = 1'b1;
            wr.next_addr = node_r;
            wr.next_link = dllm_pkg::to_link(anchor_r);
            wr.prev_we   = 1'b1;
            wr.prev_addr = node_r;
            wr.prev_link = rd.prev_link;
            wr.data_we   = 1'b1;
            wr.data_addr = node_r;
            wr.data_word = data_r;
            if (front_r == dllm_pkg::to_link(anchor_r)) begin
              front_nxt = dllm_pkg::to_link(node_r);
            end
          end
          dllm_pkg::OP_REM_FRONT: begin
            if (go_r) begin
              res_valid_nxt = 1'b1;
              res_node_nxt  = front_r[dllm_pkg::NODE_BITS-1:0];
              if (dllm_pkg::is_slot(rd.next_link)) begin
                front_nxt = rd.next_link;
              end else begin
                front_nxt = dllm_pkg::LINK_NONE;
                back_nxt  = dllm_pkg::LINK_NONE;
              end
            end
          end
          dllm_pkg::OP_REM_BACK: begin
            if (go_r) begin
              res_valid_nxt = 1'b1;
              res_node_nxt  = back_r[dllm_pkg::NODE_BITS-1:0];
              if (dllm_pkg::is_slot(rd.prev_link)) begin
                back_nxt = rd.prev_link;
              end else begin
                front_nxt = dllm_pkg::LINK_NONE;
                back_nxt  = dllm_pkg::LINK_NONE;
              end
            end
          end
          dllm_pkg::OP_REM_NODE: begin
            res_valid_nxt = 1'b1;
            res_node_nxt  = node_r;
            // Unhook from the previous neighbor
            wr.next_we    = dllm_pkg::is_slot(rd.prev_link);
            wr.next_addr  = rd.prev_link[dllm_pkg::NODE_BITS-1:0];
            wr.next_link  = rd.next_link;
            if (front_r == dllm_pkg::to_link(node_r)) begin
              nf = rd.next_link;
            end
            if (back_r == dllm_pkg::to_link(node_r)) begin
              nb = rd.prev_link;
            end
            if (!dllm_pkg::is_slot(nf) || !dllm_pkg::is_slot(nb)) begin
              front_nxt = dllm_pkg::LINK_NONE;
              back_nxt  = dllm_pkg::LINK_NONE;
            end else begin
              front_nxt = nf;
              back_nxt  = nb;
            end
          end
          dllm_pkg::OP_CLEAR: begin
            front_nxt = dllm_pkg::LINK_NONE;
            back_nxt  = dllm_pkg::LINK_NONE;
          end
          default: begin
          end
        endcase
      end

      ST_FIX: begin
        case (op_r)
          dllm_pkg::OP_INS_FRONT: begin
            wr.prev_we   = 1'b1;
            wr.prev_addr = node_r;
            wr.prev_link = dllm_pkg::LINK_NONE;
          end
          dllm_pkg::OP_INS_BACK: begin
            wr.next_we   = 1'b1;
            wr.next_addr = node_r;
            wr.next_link = dllm_pkg::LINK_NONE;
          end
          dllm_pkg::OP_INS_AFTER: begin
            wr.prev_we   = dllm_pkg::is_slot(rd.next_link);
            wr.prev_addr = rd.next_link[dllm_pkg::NODE_BITS-1:0];
            wr.prev_link = dllm_pkg::to_link(node_r);
            wr.next_we   = 1'b1;
            wr.next_addr = anchor_r;
            wr.next_link = dllm_pkg::to_link(node_r);
          end
          dllm_pkg::OP_INS_BEFORE: begin
            wr.next_we   = dllm_pkg::is_slot(rd.prev_link);
            wr.next_addr = rd.prev_link[dllm_pkg::NODE_BITS-1:0];
            wr.next_link = dllm_pkg::to_link(node_r);
            wr.prev_we   = 1'b1;
            wr.prev_addr = anchor_r;
            wr.prev_link = dllm_pkg::to_link(node_r);
          end
          dllm_pkg::OP_REM_FRONT: begin
            wr.prev_we   = go_r && dllm_pkg::is_slot(rd.next_link);
            wr.prev_addr = rd.next_link[dllm_pkg::NODE_BITS-1:0];
            wr.prev_link = dllm_pkg::LINK_NONE;
          end
          dllm_pkg::OP_REM_BACK: begin
            wr.next_we   = go_r && dllm_pkg::is_slot(rd.prev_link);
            wr.next_addr = rd.prev_link[dllm_pkg::NODE_BITS-1:0];
            wr.next_link = dllm_pkg::LINK_NONE;
          end
          dllm_pkg::OP_REM_NODE: begin
            // Unhook from the next neighbor
            wr.prev_we   = dllm_pkg::is_slot(rd.next_link);
            wr.prev_addr = rd.next_link[dllm_pkg::NODE_BITS-1:0];
            wr.prev_link = rd.prev_link;
          end
          default: begin
          end
        endcase
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end

      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drop the result once taken, raise it on load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= dllm_pkg::LINK_NONE;
      back_r      <= dllm_pkg::LINK_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the item at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op;
      node_r   <= in_ch.node_index;
      anchor_r <= in_ch.anchor_index;
      data_r   <= in_ch.payload;
      go_r     <= in_go;
    end
    res_valid_r <= res_valid_nxt;
    res_node_r  <= res_node_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_removed_valid_r <= res_valid_r;
      out_removed_node_r  <= res_valid_r ? res_node_r : '0;
      out_removed_data_r  <= res_valid_r ? rd.data_word : '0;
      out_list_empty_r    <= !dllm_pkg::is_slot(front_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_valid = out_removed_valid_r;
  assign out_ch.removed_node  = out_removed_node_r;
  assign out_ch.removed_data  = out_removed_data_r;
  assign out_ch.list_empty    = out_list_empty_r;

endmodule

`default_nettype wire

// ===== rtl/core/dllm_store.sv =====
// Node slot store: previous links, next links and payloads, registered read.
`timescale 1ns / 1ps
`default_nettype none

module dllm_store (
  input  wire logic              clk,
  input  wire dllm_pkg::mem_wr_t wr,
  input  wire logic              rd_en,
  input  wire dllm_pkg::node_t   rd_addr,
  output dllm_pkg::mem_rd_t      rd
);

  dllm_pkg::link_t   prev_mem [dllm_pkg::POOL_NODES];
  dllm_pkg::link_t   next_mem [dllm_pkg::POOL_NODES];
  dllm_pkg::word_t   data_mem [dllm_pkg::POOL_NODES];
  dllm_pkg::mem_rd_t rd_r;

  // Write each store at its own address
  always_ff @(posedge clk) begin
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_link;
    end
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_link;
    end
    if (wr.data_we) begin
      data_mem[wr.data_addr] <= wr.data_word;
    end
  end

  // Read one slot from all stores, hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.prev_link <= prev_mem[rd_addr];
      rd_r.next_link <= next_mem[rd_addr];
      rd_r.data_word <= data_mem[rd_addr];
    end
  end

  assign rd = rd_r;

endmodule

`default_nettype wire

// ===== rtl/core/dllm_checker.sv =====
// Port-level checks for the doubly linked list manager, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dllm_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic            removed_valid,
  input wire dllm_pkg::node_t removed_node,
  input wire dllm_pkg::word_t removed_data,
  input wire logic            list_empty
);

  // A stalled result keeps its valid and its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(removed_valid) &&
      $stable(removed_node) && $stable(removed_data) && $stable(list_empty))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The block is busy in the link update and fix-up states after an item is accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("item accepted while busy");

  // Nothing removed means zero node and data
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !removed_valid |-> removed_node == '0 && removed_data == '0)
    else $error("fields set with nothing removed");

endmodule

bind doubly_linked_list_manager dllm_checker u_dllm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .removed_valid (out_ch.removed_valid),
  .removed_node  (out_ch.removed_node),
  .removed_data  (out_ch.removed_data),
  .list_empty    (out_ch.list_empty)
);

`default_nettype wire
